/* src/ssh_kexinit_fingerprint_string_assert.svh */
// Assertion macros for the key-exchange-init fingerprint string block.
// Included by the top level; no other dependencies.
`ifndef SSH_KEXINIT_FINGERPRINT_STRING_ASSERT_SVH
`define SSH_KEXINIT_FINGERPRINT_STRING_ASSERT_SVH
`ifndef SYNTH
// Check a property on every edge outside reset.
`define SKFP_ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("skfp assertion failed");
// Check a property on every edge, reset included.
`define SKFP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("skfp assertion failed");
`else
`define SKFP_ASSERT_CLK(label, clk, rstn, prop)
`define SKFP_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* src/skfp_pkg.sv */
// Shared types, constants and helpers for the fingerprint string block.
// No dependencies.
package skfp_pkg;

    localparam int unsigned HEADER_BYTES = 22;
    localparam int unsigned LEN_LIMIT    = 65565;
    localparam logic [7:0]  SEPARATOR    = 8'h3B;
    localparam logic [2:0]  LAST_FIELD   = 3'd7;
    localparam logic [2:0]  FIRST_COMP   = 3'd6;
    localparam logic [16:0] SAT17        = 17'h1FFFF;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

    // One result item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_summary;
        logic        status;
        logic [15:0] string_length;
    } result_t;

    // Results caused by one input item: one or two
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic sec_valid;
    } back_stat_t;

    // Field 0 always goes out; fields 2..7 by direction, even ones for the client
    function automatic logic field_emitted(input logic [2:0] f, input logic client);
        logic r;
        if (f == 3'd0) begin
            r = 1'b1;
        end else if (f == 3'd1) begin
            r = 1'b0;
        end else begin
            r = (f[0] == 1'b0) == client;
        end
        return r;
    endfunction

endpackage

/* src/skfp_front.sv */
// Front end: parses payload bytes and classifies each into queued results.
// Depends on skfp_pkg.
module skfp_front import skfp_pkg::*; #(
    parameter int unsigned MAX_PAYLOAD = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic [15:0] packet_length,
    input  logic        is_client,
    input  logic        last_of_packet,
    output logic        push,
    output entry_t      push_entry
);

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_LENGTH = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [16:0] pos_reg, pos_next;
    logic [2:0]  field_reg, field_next;
    logic [31:0] shift_reg, shift_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] emit_reg, emit_next;
    logic        err_reg, err_next;

    logic        err_in;
    logic        em;
    logic [16:0] rem_dec;
    logic [31:0] shift_cat;
    logic [33:0] end_sum;
    logic        prefix_err;
    logic [1:0]  str_cnt;
    logic [7:0]  str0, str1;
    logic [17:0] emit_sum;
    logic        bad;
    logic [1:0]  keep_cnt;
    logic [1:0]  nres;
    result_t     sum_res, str_res0, str_res1;

    // Check the byte against the packet bounds
    assign err_in = err_reg || (pos_reg >= {1'b0, packet_length})
                    || (32'(packet_length) > 32'(MAX_PAYLOAD));
    assign em        = field_emitted(field_reg, is_client);
    assign rem_dec   = (rem_reg != 17'd0) ? rem_reg - 17'd1 : 17'd0;
    assign shift_cat = {shift_reg[23:0], data_byte};
    // Offset just after the prefix plus the field length
    assign end_sum   = 34'(pos_reg) + 34'd1 + 34'(shift_cat);
    assign prefix_err =
        (em && (end_sum + 34'd1 >= 34'(packet_length)))
        || ((field_reg != 3'd0) && (shift_cat > 32'(LEN_LIMIT)))
        || ((field_reg != LAST_FIELD) && (end_sum + 34'd4 >= 34'(packet_length)));

    // Walk the header, length prefixes and bodies
    always_comb begin
        err_next   = err_in;
        field_next = field_reg;
        phase_next = phase_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        str_cnt    = 2'd0;
        str0       = data_byte;
        str1       = SEPARATOR;
        if (!err_in) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (pos_reg >= 17'(HEADER_BYTES - 1)) begin
                        if (packet_length <= 16'(HEADER_BYTES + 4)) begin
                            err_next = 1'b1;
                        end else begin
                            field_next = 3'd0;
                            phase_next = PH_LENGTH;
                            shift_next = 32'd0;
                            rem_next   = 17'd4;
                        end
                    end
                end
                PH_LENGTH: begin
                    shift_next = shift_cat;
                    rem_next   = rem_dec;
                    if (rem_dec == 17'd0) begin
                        if (prefix_err) begin
                            err_next = 1'b1;
                        end else if (field_reg == LAST_FIELD && !em) begin
                            phase_next = PH_DONE;
                        end else if (shift_cat == 32'd0) begin
                            if (em && field_reg < FIRST_COMP) begin
                                str_cnt = 2'd1;
                                str0    = SEPARATOR;
                            end
                            if (field_reg == LAST_FIELD) begin
                                phase_next = PH_DONE;
                            end else begin
                                field_next = field_reg + 3'd1;
                                phase_next = PH_LENGTH;
                                shift_next = 32'd0;
                                rem_next   = 17'd4;
                            end
                        end else begin
                            phase_next = PH_BODY;
                            rem_next   = shift_cat[16:0];
                        end
                    end
                end
                PH_BODY: begin
                    if (em) begin
                        str_cnt = 2'd1;
                    end
                    rem_next = rem_dec;
                    if (rem_dec == 17'd0) begin
                        if (em && field_reg < FIRST_COMP) begin
                            str_cnt = 2'd2;
                        end
                        if (field_reg == LAST_FIELD) begin
                            phase_next = PH_DONE;
                        end else begin
                            field_next = field_reg + 3'd1;
                            phase_next = PH_LENGTH;
                            shift_next = 32'd0;
                            rem_next   = 17'd4;
                        end
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Count string bytes, saturating
    assign emit_sum  = 18'(emit_reg) + 18'(str_cnt);
    assign emit_next = err_next ? emit_reg
                     : ((emit_sum > 18'(SAT17)) ? SAT17 : emit_sum[16:0]);
    assign pos_next  = (pos_reg == SAT17) ? SAT17 : pos_reg + 17'd1;

    // Build the results; drop string bytes of a bad packet's last item
    assign bad      = err_next || (phase_next != PH_DONE);
    assign keep_cnt = (last_of_packet && bad) ? 2'd0 : str_cnt;
    assign nres     = keep_cnt + {1'b0, last_of_packet};

    assign sum_res  = '{out_byte: 8'd0, is_summary: 1'b1, status: bad,
                        string_length: bad ? 16'd0 : emit_next[15:0]};
    assign str_res0 = '{out_byte: str0, is_summary: 1'b0, status: 1'b0,
                        string_length: 16'd0};
    assign str_res1 = '{out_byte: str1, is_summary: 1'b0, status: 1'b0,
                        string_length: 16'd0};

    assign push           = accept && (nres != 2'd0);
    assign push_entry.two = (nres == 2'd2);
    assign push_entry.r0  = (keep_cnt != 2'd0) ? str_res0 : sum_res;
    assign push_entry.r1  = (keep_cnt == 2'd2) ? str_res1 : sum_res;

    // Advance the parser; clear it after the last item of a packet
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && last_of_packet)) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= 17'd0;
            field_reg <= 3'd0;
            shift_reg <= 32'd0;
            rem_reg   <= 17'd0;
            emit_reg  <= 17'd0;
            err_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            field_reg <= field_next;
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
            emit_reg  <= emit_next;
            err_reg   <= err_next;
        end
    end

endmodule

/* src/skfp_queue.sv */
// Short queue of classified items between the front and back ends.
// Depends on skfp_pkg.
module skfp_queue import skfp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  entry_t  push_entry,
    input  logic    pop,
    output entry_t  head,
    output q_stat_t stat
);

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_reg, rd_reg;
    logic [QPTR_W:0]     count_reg;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = slot_reg[rd_reg];

    // Store on push
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_entry;
        end
    end

    // Move pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

/* src/skfp_back.sv */
// Back end: serializes queued items into single result items.
// Depends on skfp_pkg.
module skfp_back import skfp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  entry_t     head,
    input  q_stat_t    q_stat,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output result_t    m_res,
    output back_stat_t stat
);

    logic    valid_reg;
    result_t out_reg;
    logic    sec_valid_reg;
    result_t sec_reg;
    logic    slot_free;

    assign slot_free = !valid_reg || m_ready;
    assign pop       = slot_free && !sec_valid_reg && !q_stat.empty;
    assign m_valid   = valid_reg;
    assign m_res     = out_reg;
    assign stat.sec_valid = sec_valid_reg;

    // Hold the output; refill from the second slot first, then the queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            sec_valid_reg <= 1'b0;
        end else if (slot_free) begin
            if (sec_valid_reg) begin
                valid_reg     <= 1'b1;
                sec_valid_reg <= 1'b0;
            end else if (!q_stat.empty) begin
                valid_reg     <= 1'b1;
                sec_valid_reg <= head.two;
            end else begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Load payload registers
    always_ff @(posedge aclk) begin
        if (slot_free) begin
            if (sec_valid_reg) begin
                out_reg <= sec_reg;
            end else if (!q_stat.empty) begin
                out_reg <= head.r0;
                sec_reg <= head.r1;
            end
        end
    end

endmodule

/* src/ssh_kexinit_fingerprint_string.sv */
// Top level of the key-exchange-init fingerprint string block.
// Depends on skfp_pkg, skfp_front, skfp_queue, skfp_back and the assertion header.
//
// Takes one payload byte per cycle and returns the fingerprint string bytes
// (key exchange list plus the chosen direction's cipher, MAC and compression
// lists, ';' between them) followed by one summary item per packet with the
// status and string length. A byte that yields two results (the final byte
// of a field plus its ';', or the final string byte plus the summary) goes
// out as two separate items through the single result port. A four-entry
// queue between parser and output absorbs these, so input stalls only when
// the result side falls behind. A result passes through a queue slot and
// the output register. No clearing pass follows reset.
`include "ssh_kexinit_fingerprint_string_assert.svh"
module ssh_kexinit_fingerprint_string import skfp_pkg::*; #(
    parameter int unsigned MAX_PAYLOAD = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_packet_length,
    input  logic        s_is_client,
    input  logic        s_last_of_packet,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_is_summary,
    output logic        m_status,
    output logic [15:0] m_string_length
);

    logic       accept;
    logic       q_push, q_pop;
    entry_t     push_entry, head;
    q_stat_t    q_stat;
    back_stat_t back_stat;
    result_t    m_res;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    skfp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .data_byte      (s_data_byte),
        .packet_length  (s_packet_length),
        .is_client      (s_is_client),
        .last_of_packet (s_last_of_packet),
        .push           (q_push),
        .push_entry     (push_entry)
    );

    skfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .stat       (q_stat)
    );

    skfp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_stat  (q_stat),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res),
        .stat    (back_stat)
    );

    assign m_out_byte      = m_res.out_byte;
    assign m_is_summary    = m_res.is_summary;
    assign m_status        = m_res.status;
    assign m_string_length = m_res.string_length;

    `SKFP_ASSERT_CLK(a_no_push_full, aclk, aresetn, q_push |-> !q_stat.full)
    `SKFP_ASSERT_CLK(a_bad_len_zero, aclk, aresetn, (m_valid && m_is_summary && m_status) |-> (m_string_length == 16'd0))
    `SKFP_ASSERT_CLK(a_sec_has_out, aclk, aresetn, back_stat.sec_valid |-> m_valid)
    `SKFP_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid)

endmodule
